>>> sv/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg: shared types and codes for the multi-timer countdown table
// Command and response word layouts, function codes, entry status codes and response kinds.
// ----------------------------------------------------------------------------
package mtt_pkg;

    // function codes carried in a command word
    localparam logic [2:0] FUNC_ALLOC   = 3'd0;
    localparam logic [2:0] FUNC_FREE    = 3'd1;
    localparam logic [2:0] FUNC_INIT    = 3'd2;
    localparam logic [2:0] FUNC_SETTIME = 3'd3;
    localparam logic [2:0] FUNC_TICK    = 3'd4;

    // entry status codes
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    // response kinds
    localparam logic KIND_ALLOC  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  entry_index;
        logic [2:0]  destination;
        logic [7:0]  data_byte;
        logic [31:0] timeout;
    } cmd_word_t;

    typedef struct packed {
        logic        kind;
        logic        found;
        logic [3:0]  entry_out;
        logic [2:0]  destination_out;
        logic [7:0]  data_out;
        logic [31:0] tick_total;
        logic        last;
    } rsp_word_t;

endpackage

>>> sv/multi_timer_table.sv
// Free, init and set timeout are applied while idle and start no walk; a tick walks every entry,
// one per cycle unless a stalled response port holds the walk, and marks its last result;
// an alloc stops at the first free entry.
// The command port stays closed until a scanning word has finished, since the single
// read port of the entry memory walks the entries one by one; a stalled response port holds the walk.
// Reset: asynchronous, active low; all entries free, tick counter zero.
// ----------------------------------------------------------------------------
// multi_timer_table: table of countdown timers
// Entry state lives in two synchronous memories (control and payload); a
// read-modify-write pipeline walks them for alloc and tick commands.
// ----------------------------------------------------------------------------
module multi_timer_table #(
    parameter int TIMERS    = 16,
    parameter int DEST_BITS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mtt_pkg::cmd_word_t cmd,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    output mtt_pkg::rsp_word_t rsp,
    output logic               rsp_valid,
    input  logic               rsp_stall
);
    import mtt_pkg::*;

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CW = IW + 1;
    localparam int PW = DEST_BITS + 8;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    // control state
    logic [1:0]        state_reg, state_next;
    logic              op_alloc_reg, op_alloc_next;
    logic [CW-1:0]     issue_reg, issue_next;
    logic              p_vld_reg, p_vld_next;
    logic [IW-1:0]     p_idx_reg, p_idx_next;
    logic              pend_vld_reg, pend_vld_next;
    logic              rsp_vld_reg, rsp_vld_next;
    logic [31:0]       tick_cnt_reg, tick_cnt_next;
    logic [TIMERS-1:0] vld_reg, vld_next;

    // payload registers
    rsp_word_t         pend_reg, pend_next;
    rsp_word_t         rsp_reg, rsp_next;

    // entry memories
    logic [33:0]       ctl_mem [TIMERS];
    logic [PW-1:0]     pay_mem [TIMERS];
    logic [33:0]       ctl_q;
    logic [PW-1:0]     pay_q;
    logic              vld_q;

    logic              cmd_acc;
    logic              idx_ok;
    logic [IW-1:0]     cmd_idx;
    logic [IW-1:0]     rd_addr;
    logic              ctl_we;
    logic [IW-1:0]     ctl_waddr;
    logic [33:0]       ctl_wdata;
    logic              pay_we;

    logic [1:0]        st_q;
    logic [31:0]       rem_q;
    logic [31:0]       dec;
    logic              run_hit;
    logic              expire;
    logic              free_hit;
    logic              p_last;
    logic              emit;
    logic              out_room;
    logic              hold;
    logic              go;
    logic              scan_end;
    logic              issue_live;
    rsp_word_t         new_rsp;

    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign idx_ok    = int'(cmd.entry_index) < TIMERS;
    assign cmd_idx   = IW'(cmd.entry_index);
    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    // decode of the entry on the memory outputs
    assign st_q     = ctl_q[33:32];
    assign rem_q    = ctl_q[31:0];
    assign dec      = rem_q - 32'd1;
    assign run_hit  = vld_q && (st_q == ST_RUN);
    assign expire   = run_hit && (dec == 32'd0);
    assign free_hit = !vld_q || (st_q == ST_FREE);
    assign p_last   = (p_idx_reg == IW'(TIMERS - 1));

    // pipeline hold: a new result while the pending one cannot move on
    assign emit       = p_vld_reg && (op_alloc_reg ? (free_hit || p_last) : expire);
    assign out_room   = !rsp_vld_reg || !rsp_stall;
    assign hold       = emit && pend_vld_reg && !out_room;
    assign go         = p_vld_reg && !hold;
    assign scan_end   = go && (p_last || (op_alloc_reg && free_hit));
    assign issue_live = (issue_reg < CW'(TIMERS));

    // read address: re-read the held entry, else the next one
    assign rd_addr = (hold || !issue_live) ? p_idx_reg : issue_reg[IW-1:0];

    // result built from the entry in the process stage
    always_comb
    begin
        new_rsp                 = '0;
        new_rsp.kind            = op_alloc_reg ? KIND_ALLOC : KIND_EXPIRY;
        new_rsp.found           = op_alloc_reg && free_hit;
        new_rsp.tick_total      = tick_cnt_reg;
        new_rsp.last            = 1'b0;
        if (!op_alloc_reg || free_hit)
        begin
            new_rsp.entry_out = 4'(p_idx_reg);
        end
        if (!op_alloc_reg)
        begin
            new_rsp.destination_out = 3'(pay_q[PW-1:8]);
            new_rsp.data_out        = pay_q[7:0];
        end
    end

    // control memory write port: set timeout or scan write-back
    always_comb
    begin
        ctl_we    = 1'b0;
        ctl_waddr = p_idx_reg;
        ctl_wdata = '0;
        if (cmd_acc && (cmd.func == FUNC_SETTIME) && idx_ok)
        begin
            ctl_we    = 1'b1;
            ctl_waddr = cmd_idx;
            ctl_wdata = {ST_RUN, cmd.timeout};
        end
        else if (state_reg == S_SCAN && go)
        begin
            if (op_alloc_reg)
            begin
                ctl_we    = free_hit;
                ctl_wdata = {ST_ALLOC, rem_q};
            end
            else
            begin
                ctl_we    = run_hit;
                ctl_wdata = {(expire ? ST_ALLOC : ST_RUN), dec};
            end
        end
    end

    assign pay_we = cmd_acc && (cmd.func == FUNC_INIT) && idx_ok;

    // entry memories with a registered read port
    always_ff @(posedge clk)
    begin
        if (ctl_we)
        begin
            ctl_mem[ctl_waddr] <= ctl_wdata;
        end
        ctl_q <= ctl_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[cmd_idx] <= {DEST_BITS'(cmd.destination), cmd.data_byte};
        end
        pay_q <= pay_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        vld_q <= vld_reg[rd_addr];
    end

    // sequencer and result path
    always_comb
    begin
        state_next    = state_reg;
        op_alloc_next = op_alloc_reg;
        issue_next    = issue_reg;
        p_vld_next    = p_vld_reg;
        p_idx_next    = p_idx_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        tick_cnt_next = tick_cnt_reg;
        vld_next      = vld_reg;
        rsp_next      = rsp_reg;
        rsp_vld_next  = rsp_vld_reg && rsp_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    if (cmd.func == FUNC_ALLOC || cmd.func == FUNC_TICK)
                    begin
                        state_next    = S_SCAN;
                        op_alloc_next = (cmd.func == FUNC_ALLOC);
                        issue_next    = '0;
                        p_vld_next    = 1'b0;
                    end
                    if (cmd.func == FUNC_TICK)
                    begin
                        tick_cnt_next = tick_cnt_reg + 32'd1;
                    end
                    if (cmd.func == FUNC_FREE && idx_ok)
                    begin
                        vld_next[cmd_idx] = 1'b0;
                    end
                    if (cmd.func == FUNC_SETTIME && idx_ok)
                    begin
                        vld_next[cmd_idx] = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (!hold)
                begin
                    p_vld_next = issue_live && !scan_end;
                    p_idx_next = issue_reg[IW-1:0];
                    if (issue_live)
                    begin
                        issue_next = issue_reg + CW'(1);
                    end
                end
                if (go && op_alloc_reg && free_hit)
                begin
                    vld_next[p_idx_reg] = 1'b1;
                end
                if (go && emit)
                begin
                    if (pend_vld_reg)
                    begin
                        rsp_next     = pend_reg;
                        rsp_vld_next = 1'b1;
                    end
                    pend_next     = new_rsp;
                    pend_vld_next = 1'b1;
                end
                if (scan_end)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_room)
                begin
                    rsp_next      = pend_reg;
                    rsp_next.last = 1'b1;
                    rsp_vld_next  = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_alloc_reg <= 1'b0;
            issue_reg    <= '0;
            p_vld_reg    <= 1'b0;
            p_idx_reg    <= '0;
            pend_vld_reg <= 1'b0;
            rsp_vld_reg  <= 1'b0;
            tick_cnt_reg <= '0;
            vld_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_alloc_reg <= op_alloc_next;
            issue_reg    <= issue_next;
            p_vld_reg    <= p_vld_next;
            p_idx_reg    <= p_idx_next;
            pend_vld_reg <= pend_vld_next;
            rsp_vld_reg  <= rsp_vld_next;
            tick_cnt_reg <= tick_cnt_next;
            vld_reg      <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

endmodule

>>> sv/mtt_checker.sv
// ----------------------------------------------------------------------------
// mtt_checker: port-level checks for the multi-timer table
// Watches the command and response ports and flags protocol or result slips.
// ----------------------------------------------------------------------------
module mtt_checker (
    input logic               clk,
    input logic               rst_n,
    input mtt_pkg::cmd_word_t cmd,
    input logic               cmd_valid,
    input logic               cmd_stall,
    input mtt_pkg::rsp_word_t rsp,
    input logic               rsp_valid,
    input logic               rsp_stall
);
    import mtt_pkg::*;

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response word changed while stalled");

    // an alloc reply is the only word of its command
    a_alloc_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind == KIND_ALLOC) |-> rsp.last)
        else $error("alloc reply not marked last");

    // expiry words never report found; a failed alloc names entry zero
    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.kind == KIND_EXPIRY) && !rsp.found) ||
                      ((rsp.kind == KIND_ALLOC) && (rsp.found ||
                       (rsp.entry_out == 4'd0))))
        else $error("inconsistent response fields");

    // a scanning command keeps the command port closed the next cycle
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall &&
        (cmd.func == FUNC_ALLOC || cmd.func == FUNC_TICK) |=> cmd_stall)
        else $error("command accepted during a table walk");

endmodule

bind multi_timer_table mtt_checker u_mtt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
);

>>> dv/multi_timer_table_tb.sv
// ----------------------------------------------------------------------------
// multi_timer_table_tb: self-checking bench for the countdown timer table
// Drives a table of directed commands, then random command traffic, through
// the valid/stall ports with random idling and back-pressure on both sides.
// A software copy of the timer table predicts alloc replies and expiry words, but directed
// rows may carry their own reply; each response word is checked field by field against the oldest word due.
// ----------------------------------------------------------------------------
module multi_timer_table_tb;
    import mtt_pkg::*;

    localparam int TIMERS       = 16;
    localparam int DEST_BITS    = 3;
    localparam int RANDOM_WORDS = 130;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 400000;

    // function codes the block has no use for
    localparam logic [2:0] FUNC_SPARE0 = 3'd5;
    localparam logic [2:0] FUNC_SPARE1 = 3'd6;
    localparam logic [2:0] FUNC_SPARE2 = 3'd7;

    typedef struct {
        cmd_word_t w;
        int        reps;
        bit        typed;
        rsp_word_t want;
    } plan_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    cmd_word_t cmd;
    logic      cmd_valid;
    logic      cmd_stall;
    rsp_word_t rsp;
    logic      rsp_valid;
    logic      rsp_stall;

    // shadow of the timer table
    logic [1:0]  entry_state [TIMERS];
    logic [31:0] count_left  [TIMERS];
    logic [7:0]  entry_byte  [TIMERS];
    logic [2:0]  entry_queue [TIMERS];
    logic [31:0] ticks_seen;

    rsp_word_t   due_rsp [$];
    plan_row_t   plan [$];
    int          words_checked;
    int          mismatch_count;
    bit          calm;
    bit          squeeze_now;

    multi_timer_table #(
        .TIMERS    (TIMERS),
        .DEST_BITS (DEST_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one line per mismatch
    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at response word %0d: %s", words_checked, what);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
        begin
            flag_mismatch($sformatf("%s got 'h%0h want 'h%0h", name, got, want));
        end
    endtask

    // apply one accepted command to the shadow table, queue the words it causes
    function automatic void apply_command(input cmd_word_t w, ref rsp_word_t outs[$]);
        rsp_word_t held;
        bit        have_held;
        int        i;
        held = '0;
        have_held = 1'b0;
        case (w.func)
            FUNC_ALLOC:
            begin
                held.kind = KIND_ALLOC;
                for (i = 0; i < TIMERS; i++)
                begin
                    if (!held.found && entry_state[i] == ST_FREE)
                    begin
                        entry_state[i] = ST_ALLOC;
                        held.found = 1'b1;
                        held.entry_out = 4'(i);
                    end
                end
                held.tick_total = ticks_seen;
                have_held = 1'b1;
            end
            FUNC_FREE:
            begin
                entry_state[w.entry_index] = ST_FREE;
            end
            FUNC_INIT:
            begin
                entry_queue[w.entry_index] = w.destination;
                entry_byte[w.entry_index] = w.data_byte;
            end
            FUNC_SETTIME:
            begin
                count_left[w.entry_index] = w.timeout;
                entry_state[w.entry_index] = ST_RUN;
            end
            FUNC_TICK:
            begin
                ticks_seen = ticks_seen + 32'd1;
                // expiries leave in ascending entry order; hold one back to mark it last
                for (i = 0; i < TIMERS; i++)
                begin
                    if (entry_state[i] == ST_RUN)
                    begin
                        count_left[i] = count_left[i] - 32'd1;
                        if (count_left[i] == 32'd0)
                        begin
                            entry_state[i] = ST_ALLOC;
                            if (have_held)
                            begin
                                outs.push_back(held);
                            end
                            held = '0;
                            held.kind = KIND_EXPIRY;
                            held.entry_out = 4'(i);
                            held.destination_out = entry_queue[i];
                            held.data_out = entry_byte[i];
                            held.tick_total = ticks_seen;
                            have_held = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (have_held)
        begin
            held.last = 1'b1;
            outs.push_back(held);
        end
    endfunction

    function automatic rsp_word_t reply(input logic kind, input logic found,
                                        input logic [3:0] entry, input logic [2:0] dest,
                                        input logic [7:0] data, input logic [31:0] ticks);
        rsp_word_t r;
        r.kind = kind;
        r.found = found;
        r.entry_out = entry;
        r.destination_out = dest;
        r.data_out = data;
        r.tick_total = ticks;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void add_row(input logic [2:0] func, input logic [3:0] idx,
                                    input logic [2:0] dest, input logic [7:0] data,
                                    input logic [31:0] tmo, input int reps,
                                    input bit typed, input rsp_word_t want);
        plan_row_t row;
        row.w.func = func;
        row.w.entry_index = idx;
        row.w.destination = dest;
        row.w.data_byte = data;
        row.w.timeout = tmo;
        row.reps = reps;
        row.typed = typed;
        row.want = want;
        plan.push_back(row);
    endfunction

    // random command: mostly short timers so that expiries keep coming
    function automatic cmd_word_t random_word();
        cmd_word_t w;
        int        roll;
        int        span;
        roll = $urandom_range(99);
        span = $urandom_range(99);
        w.entry_index = 4'($urandom_range(TIMERS - 1));
        w.destination = 3'($urandom);
        w.data_byte = 8'($urandom);
        w.timeout = $urandom;
        if (roll < 34)
        begin
            w.func = FUNC_TICK;
        end
        else if (roll < 54)
        begin
            w.func = FUNC_SETTIME;
            if (span < 85)
            begin
                w.timeout = $urandom_range(6, 1);
            end
            else if (span < 90)
            begin
                w.timeout = '0;
            end
            else if (span >= 95)
            begin
                w.timeout = $urandom_range(40, 7);
            end
        end
        else if (roll < 66)
        begin
            w.func = FUNC_INIT;
        end
        else if (roll < 80)
        begin
            w.func = FUNC_ALLOC;
        end
        else if (roll < 90)
        begin
            w.func = FUNC_FREE;
        end
        else
        begin
            w.func = 3'($urandom_range(FUNC_SPARE2, FUNC_SPARE0));
        end
        return w;
    endfunction

    // offer one word, wait for it to be taken, then predict
    task automatic send_word(input cmd_word_t w, input bit typed, input rsp_word_t want);
        rsp_word_t scratch [$];
        while (!calm && $urandom_range(99) < 38)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd <= w;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        if (typed)
        begin
            apply_command(w, scratch);
            due_rsp.push_back(want);
        end
        else
        begin
            apply_command(w, due_rsp);
        end
    endtask

    // response checker
    always @(posedge clk)
    begin : rsp_check
        rsp_word_t want;
        if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (due_rsp.size() == 0)
            begin
                flag_mismatch("response word with nothing due");
            end
            else
            begin
                want = due_rsp.pop_front();
                compare_field("kind", 32'(rsp.kind), 32'(want.kind));
                compare_field("found", 32'(rsp.found), 32'(want.found));
                compare_field("entry_out", 32'(rsp.entry_out), 32'(want.entry_out));
                compare_field("destination_out", 32'(rsp.destination_out),
                              32'(want.destination_out));
                compare_field("data_out", 32'(rsp.data_out), 32'(want.data_out));
                compare_field("tick_total", rsp.tick_total, want.tick_total);
                compare_field("last", 32'(rsp.last), 32'(want.last));
            end
            words_checked++;
        end
    end

    // response back-pressure, with one long hold-off to fill the block
    initial
    begin : rsp_pacing
        int unsigned held_cycles;
        bit          squeezed;
        rsp_stall <= 1'b0;
        squeezed = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze_now && !squeezed)
            begin
                squeezed = 1'b1;
                rsp_stall <= 1'b1;
                held_cycles = 0;
                while (held_cycles < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held_cycles++;
                end
                rsp_stall <= 1'b0;
            end
            else
            begin
                rsp_stall <= !calm && ($urandom_range(99) < 38);
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        cmd_word_t  w;
        logic [3:0] step;
        int         sent;
        int         k;
        bit         drained;
        rst_n <= 1'b0;
        cmd <= '0;
        cmd_valid <= 1'b0;
        calm = 1'b0;
        squeeze_now = 1'b0;
        drained = 1'b0;
        words_checked = 0;
        mismatch_count = 0;
        ticks_seen = '0;
        for (k = 0; k < TIMERS; k++)
        begin
            entry_state[k] = ST_FREE;
            count_left[k] = '0;
            entry_byte[k] = '0;
            entry_queue[k] = '0;
        end

        // directed plan: repeated rows step the index and vary dest/data
        add_row(FUNC_ALLOC, 4'd0, 3'd0, 8'h00, 32'd0, 1, 1'b1,
                reply(KIND_ALLOC, 1'b1, 4'd0, 3'd0, 8'h00, 32'd0));
        add_row(FUNC_TICK, 4'd0, 3'd0, 8'h00, 32'd0, 1, 1'b0, '0);
        add_row(FUNC_INIT, 4'd0, 3'd7, 8'hFF, 32'd0, TIMERS, 1'b0, '0);
        add_row(FUNC_SETTIME, 4'd0, 3'd0, 8'h00, 32'd1, 1, 1'b0, '0);
        add_row(FUNC_TICK, 4'd0, 3'd0, 8'h00, 32'd0, 1, 1'b1,
                reply(KIND_EXPIRY, 1'b0, 4'd0, 3'd7, 8'hFF, 32'd2));
        // every entry runs out on the same tick
        add_row(FUNC_SETTIME, 4'd0, 3'd0, 8'h00, 32'd2, TIMERS, 1'b0, '0);
        add_row(FUNC_TICK, 4'd0, 3'd0, 8'h00, 32'd0, 1, 1'b0, '0);
        add_row(FUNC_TICK, 4'd0, 3'd0, 8'h00, 32'd0, 1, 1'b0, '0);
        // table full: alloc finds nothing
        add_row(FUNC_ALLOC, 4'd0, 3'd0, 8'h00, 32'd0, 1, 1'b1,
                reply(KIND_ALLOC, 1'b0, 4'd0, 3'd0, 8'h00, 32'd4));
        add_row(FUNC_FREE, 4'd15, 3'd0, 8'h00, 32'd0, 1, 1'b0, '0);
        add_row(FUNC_ALLOC, 4'd0, 3'd0, 8'h00, 32'd0, 1, 1'b1,
                reply(KIND_ALLOC, 1'b1, 4'd15, 3'd0, 8'h00, 32'd4));
        // zero timeout on a freed entry wraps round; longest timeout on the top entry
        add_row(FUNC_FREE, 4'd0, 3'd0, 8'h00, 32'd0, 1, 1'b0, '0);
        add_row(FUNC_SETTIME, 4'd0, 3'd0, 8'h00, 32'd0, 1, 1'b0, '0);
        add_row(FUNC_SETTIME, 4'd15, 3'd0, 8'h00, 32'hFFFF_FFFF, 1, 1'b0, '0);
        // unused function codes are dropped
        add_row(FUNC_SPARE0, 4'd15, 3'd7, 8'hFF, 32'hFFFF_FFFF, 1, 1'b0, '0);
        add_row(FUNC_SPARE1, 4'd15, 3'd7, 8'hFF, 32'hFFFF_FFFF, 1, 1'b0, '0);
        add_row(FUNC_SPARE2, 4'd15, 3'd7, 8'hFF, 32'hFFFF_FFFF, 1, 1'b0, '0);
        add_row(FUNC_TICK, 4'd0, 3'd0, 8'h00, 32'd0, 1, 1'b0, '0);
        add_row(FUNC_INIT, 4'd15, 3'd0, 8'h00, 32'd0, 1, 1'b0, '0);
        add_row(FUNC_ALLOC, 4'd0, 3'd0, 8'h00, 32'd0, 1, 1'b1,
                reply(KIND_ALLOC, 1'b0, 4'd0, 3'd0, 8'h00, 32'd5));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
        begin
            for (k = 0; k < plan[r].reps; k++)
            begin
                step = k[3:0];
                w = plan[r].w;
                w.entry_index = w.entry_index + step;
                w.destination = w.destination ^ step[2:0];
                w.data_byte = w.data_byte ^ {step, step};
                send_word(w, plan[r].typed, plan[r].want);
            end
        end

        // random traffic; every entry has been initialised by now
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            w = random_word();
            if (sent == 30)
            begin
                squeeze_now = 1'b1;
            end
            calm = (sent >= 60 && sent < 100);
            send_word(w, 1'b0, '0);
            sent++;
            // let the block run dry once
            if (sent == 90 && !drained)
            begin
                drained = 1'b1;
                cmd_valid <= 1'b0;
                while (due_rsp.size() != 0)
                begin
                    @(posedge clk);
                end
            end
        end
        calm = 1'b0;

        cmd_valid <= 1'b0;
        while (due_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> multi_timer_table.f
sv/mtt_pkg.sv
sv/multi_timer_table.sv
sv/mtt_checker.sv
dv/multi_timer_table_tb.sv
